@@ rtl/qau_pkg.sv @@
// qau_pkg: shared types and constants of the quaternion arithmetic unit
// no dependencies; used by every module under rtl
`timescale 1ns / 1ps
package qau_pkg;

   typedef logic [2:0] kind_type;

   localparam kind_type KIND_ADD   = 3'd0;
   localparam kind_type KIND_SUB   = 3'd1;
   localparam kind_type KIND_MUL   = 3'd2;
   localparam kind_type KIND_SCALE = 3'd3;
   localparam kind_type KIND_NORM  = 3'd4;
   localparam kind_type KIND_MAT   = 3'd5;

   localparam int LANES      = 4;
   localparam int MAC_LAT    = 4;
   localparam int SQRT_LAT   = 36;
   localparam int DIV_LAT    = 18;
   localparam int PIPE_DEPTH = SQRT_LAT + DIV_LAT;

   typedef logic signed [31:0] word_type;

   typedef struct packed {
      word_type x;
      word_type y;
      logic     neg;
   } term_type;

   typedef struct packed {
      term_type [3:0] term;
      logic           dbl;
   } lane_op_type;

   typedef struct packed {
      word_type elem;
      logic     sat;
   } lane_res_type;

endpackage

@@ rtl/qau_mac.sv @@
// qau_mac: one lane, sum of four signed products, rounded to Q16.16 and clipped
// depends on qau_pkg
`timescale 1ns / 1ps
module qau_mac (
   input  logic                  clock,
   input  logic                  en,
   input  qau_pkg::lane_op_type  op,
   output qau_pkg::lane_res_type res
);

   logic signed [63:0] prod_ff [4];
   logic [3:0]         neg_ff;
   logic               dbl1_ff;
   logic signed [65:0] pair_ff [2];
   logic               dbl2_ff;
   logic signed [67:0] tot_ff;
   logic signed [67:0] tot_in;
   logic signed [67:0] sum;
   logic signed [67:0] rnd;
   logic signed [51:0] sh;
   qau_pkg::lane_res_type res_ff;
   qau_pkg::lane_res_type res_in;

   function automatic logic signed [65:0] sterm(input logic signed [63:0] p, input logic n);
      logic signed [65:0] w;
      w = 66'(p);
      return n ? -w : w;
   endfunction

   always_comb begin
      sum = 68'(pair_ff[0]) + 68'(pair_ff[1]);
      tot_in = dbl2_ff ? (sum <<< 1) : sum;
      rnd = tot_ff + 68'sd32768;
      sh = 52'(rnd >>> 16);
      if (sh > 52'sd2147483647) begin
         res_in.elem = 32'sh7FFFFFFF;
         res_in.sat = 1'b1;
      end else if (sh < -52'sd2147483648) begin
         res_in.elem = 32'sh80000000;
         res_in.sat = 1'b1;
      end else begin
         res_in.elem = 32'(sh);
         res_in.sat = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int t = 0; t < 4; t++) begin
            prod_ff[t] <= $signed(op.term[t].x) * $signed(op.term[t].y);
            neg_ff[t] <= op.term[t].neg;
         end
         dbl1_ff <= op.dbl;
         pair_ff[0] <= sterm(prod_ff[0], neg_ff[0]) + sterm(prod_ff[1], neg_ff[1]);
         pair_ff[1] <= sterm(prod_ff[2], neg_ff[2]) + sterm(prod_ff[3], neg_ff[3]);
         dbl2_ff <= dbl1_ff;
         tot_ff <= tot_in;
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule

@@ rtl/qau_sqrt.sv @@
// qau_sqrt: sum of squares of a quaternion and its integer square root, one bit a stage
// depends on qau_pkg
`timescale 1ns / 1ps
module qau_sqrt (
   input  logic                    clock,
   input  logic                    en,
   input  qau_pkg::word_type [3:0] a,
   output logic [32:0]             root,
   output logic                    zero
);

   localparam int ROOT_BITS = 33;

   logic signed [63:0] sqp [4];
   logic [62:0] sq_ff [4];
   logic [63:0] ps_ff [2];
   logic [65:0] rad_ff  [0:ROOT_BITS-1];
   logic [35:0] rem_ff  [0:ROOT_BITS-1];
   logic [32:0] root_ff [0:ROOT_BITS];
   logic        zero_ff [0:ROOT_BITS];
   logic [65:0] rad_in;

   always_comb begin
      for (int e = 0; e < 4; e++) begin
         sqp[e] = $signed(a[e]) * $signed(a[e]);
      end
      rad_in = 66'(ps_ff[0]) + 66'(ps_ff[1]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int e = 0; e < 4; e++) begin
            sq_ff[e] <= sqp[e][62:0];
         end
         ps_ff[0] <= 64'(sq_ff[0]) + 64'(sq_ff[1]);
         ps_ff[1] <= 64'(sq_ff[2]) + 64'(sq_ff[3]);
         rad_ff[0] <= rad_in;
         rem_ff[0] <= '0;
         root_ff[0] <= '0;
         zero_ff[0] <= (rad_in == '0);
      end
   end

   for (genvar i = 0; i < ROOT_BITS; i++) begin : g_step
      logic [35:0] rem_x;
      logic [35:0] trial;
      logic        ge;
      assign rem_x = {rem_ff[i][33:0], rad_ff[i][65:64]};
      assign trial = {1'b0, root_ff[i], 2'b01};
      assign ge = (rem_x >= trial);
      always_ff @(posedge clock) begin
         if (en) begin
            root_ff[i+1] <= {root_ff[i][31:0], ge};
            zero_ff[i+1] <= zero_ff[i];
         end
      end
      if (i < ROOT_BITS - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[i+1] <= ge ? (rem_x - trial) : rem_x;
               rad_ff[i+1] <= rad_ff[i] << 2;
            end
         end
      end
   end

   assign root = root_ff[ROOT_BITS];
   assign zero = zero_ff[ROOT_BITS];

endmodule

@@ rtl/qau_div.sv @@
// qau_div: one lane of normalize, rounded quotient of a part over the magnitude
// depends on qau_pkg
`timescale 1ns / 1ps
module qau_div (
   input  logic              clock,
   input  logic              en,
   input  logic [31:0]       mag,
   input  logic [32:0]       root,
   input  logic              neg,
   input  logic              clr,
   output qau_pkg::word_type quot,
   output logic              clr_o
);

   localparam int QB = 17;

   logic [50:0] rem_ff [0:QB-1];
   logic [33:0] den_ff [0:QB-1];
   logic [16:0] q_ff   [1:QB];
   logic        neg_ff [0:QB];
   logic        clr_ff [0:QB];

   // numerator 2n+m and denominator 2m give round half up of n/m
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= {2'b00, mag, 17'b0} + 51'(root);
         den_ff[0] <= {root, 1'b0};
         neg_ff[0] <= neg;
         clr_ff[0] <= clr;
      end
   end

   for (genvar i = 0; i < QB; i++) begin : g_step
      logic [50:0] dsh;
      logic        ge;
      assign dsh = 51'(den_ff[i]) << (QB - 1 - i);
      assign ge = (rem_ff[i] >= dsh);
      always_ff @(posedge clock) begin
         if (en) begin
            neg_ff[i+1] <= neg_ff[i];
            clr_ff[i+1] <= clr_ff[i];
         end
      end
      if (i == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (en) q_ff[1] <= {16'b0, ge};
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            if (en) q_ff[i+1] <= {q_ff[i][15:0], ge};
         end
      end
      if (i < QB - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[i+1] <= ge ? (rem_ff[i] - dsh) : rem_ff[i];
               den_ff[i+1] <= den_ff[i];
            end
         end
      end
   end

   always_comb begin
      if (clr_ff[QB]) quot = '0;
      else if (neg_ff[QB]) quot = -32'(q_ff[QB]);
      else quot = 32'(q_ff[QB]);
   end

   assign clr_o = clr_ff[QB];

endmodule

@@ rtl/quaternion_arithmetic_unit_top.sv @@
// quaternion_arithmetic_unit_top: issue stage, four lanes, normalize path and merge stage
// depends on qau_pkg, qau_mac, qau_sqrt, qau_div
//
// usage
// req channel: one transfer carries a kind, quaternions a and b and a scale factor
// (signed Q16.16); a transfer happens when req_valid is high and req_stall low
// rsp channel: one transfer per result; rotation matrix items give three rows,
// row 0 to 2, the last one with rsp_last set; kinds 6 and 7 give no result
// depth: set by the normalize path (36 stages for the squares and the root, an
// 18-stage divider in each lane, then the output register); every kind goes
// through the same depth so results keep their order
// throughput: one item per cycle while no stall holds the pipeline; a matrix item
// holds the issue stage for its three rows, one row at a time
// reset clears all valid bits; the pipeline then takes a transfer at once
// when the receiver stalls a valid response, the whole pipeline holds and req_stall goes high
`timescale 1ns / 1ps
module quaternion_arithmetic_unit_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_kind,
   input  logic signed [31:0] req_a_r,
   input  logic signed [31:0] req_a_i,
   input  logic signed [31:0] req_a_j,
   input  logic signed [31:0] req_a_k,
   input  logic signed [31:0] req_b_r,
   input  logic signed [31:0] req_b_i,
   input  logic signed [31:0] req_b_j,
   input  logic signed [31:0] req_b_k,
   input  logic signed [31:0] req_scale,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_elem_0,
   output logic signed [31:0] rsp_elem_1,
   output logic signed [31:0] rsp_elem_2,
   output logic signed [31:0] rsp_elem_3,
   output logic [1:0]         rsp_row,
   output logic               rsp_last,
   output logic               rsp_saturated,
   output logic               rsp_zero_magnitude
);

   localparam logic [1:0] LAST_ROW = 2'd2;
   localparam logic [1:0] IX_R = 2'd0;
   localparam logic [1:0] IX_I = 2'd1;
   localparam logic [1:0] IX_J = 2'd2;
   localparam logic [1:0] IX_Q = 2'd3;
   localparam qau_pkg::word_type ONE_Q  = 32'sd65536;
   localparam qau_pkg::word_type HALF_Q = 32'sd32768;
   localparam int D = qau_pkg::PIPE_DEPTH;

   typedef struct packed {
      logic       valid;
      logic       norm;
      logic [1:0] row;
      logic       last;
   } ctl_type;

   typedef struct packed {
      logic [31:0] mag;
      logic        neg;
   } sgn_type;

   // operands of one lane for one row
   function automatic qau_pkg::lane_op_type sel_op(
      input qau_pkg::kind_type       kind,
      input logic [1:0]              row,
      input logic [1:0]              lane,
      input qau_pkg::word_type [3:0] a,
      input qau_pkg::word_type [3:0] b,
      input qau_pkg::word_type       s
   );
      qau_pkg::lane_op_type op;
      logic [3:0] ng;
      logic [3:0] ent;
      logic [1:0] x1, y1, x2, y2;
      logic       n1, n2, one;
      op = '0;
      ng = '0;
      ent = 4'(row) * 4'd3 + 4'(lane);
      x1 = IX_R; y1 = IX_R; x2 = IX_R; y2 = IX_R;
      n1 = 1'b0; n2 = 1'b0; one = 1'b0;
      case (kind)
         qau_pkg::KIND_ADD, qau_pkg::KIND_SUB: begin
            op.term[0].x = a[lane];
            op.term[0].y = ONE_Q;
            op.term[1].x = b[lane];
            op.term[1].y = ONE_Q;
            op.term[1].neg = (kind == qau_pkg::KIND_SUB);
         end
         qau_pkg::KIND_MUL: begin
            case (lane)
               2'd0:    ng = 4'b1110;
               2'd1:    ng = 4'b1000;
               2'd2:    ng = 4'b0010;
               default: ng = 4'b0100;
            endcase
            for (int e = 0; e < 4; e++) begin
               op.term[e].x = a[e];
               op.term[e].y = b[lane ^ 2'(e)];
               op.term[e].neg = ng[e];
            end
         end
         qau_pkg::KIND_SCALE: begin
            op.term[0].x = a[lane];
            op.term[0].y = s;
         end
         qau_pkg::KIND_MAT: begin
            if (lane != IX_Q) begin
               case (ent)
                  4'd0: begin one = 1'b1; x1 = IX_J; y1 = IX_J; n1 = 1'b1;
                     x2 = IX_Q; y2 = IX_Q; n2 = 1'b1; end
                  4'd1: begin x1 = IX_I; y1 = IX_J; x2 = IX_Q; y2 = IX_R; end
                  4'd2: begin x1 = IX_I; y1 = IX_Q; x2 = IX_J; y2 = IX_R; n2 = 1'b1; end
                  4'd3: begin x1 = IX_I; y1 = IX_J; x2 = IX_Q; y2 = IX_R; n2 = 1'b1; end
                  4'd4: begin one = 1'b1; x1 = IX_I; y1 = IX_I; n1 = 1'b1;
                     x2 = IX_Q; y2 = IX_Q; n2 = 1'b1; end
                  4'd5: begin x1 = IX_J; y1 = IX_Q; x2 = IX_I; y2 = IX_R; end
                  4'd6: begin x1 = IX_I; y1 = IX_Q; x2 = IX_J; y2 = IX_R; end
                  4'd7: begin x1 = IX_J; y1 = IX_Q; x2 = IX_I; y2 = IX_R; n2 = 1'b1; end
                  default: begin one = 1'b1; x1 = IX_I; y1 = IX_I; n1 = 1'b1;
                     x2 = IX_J; y2 = IX_J; n2 = 1'b1; end
               endcase
               // constant one as 65536*32768, doubled with the rest
               op.term[0].x = one ? ONE_Q : '0;
               op.term[0].y = HALF_Q;
               op.term[1].x = a[x1];
               op.term[1].y = a[y1];
               op.term[1].neg = n1;
               op.term[2].x = a[x2];
               op.term[2].y = a[y2];
               op.term[2].neg = n2;
               op.dbl = 1'b1;
            end
         end
         default: op = '0;
      endcase
      return op;
   endfunction

   logic adv;
   logic more;

   logic                    s0_valid_ff;
   logic [1:0]              s0_row_ff;
   qau_pkg::kind_type       s0_kind_ff;
   qau_pkg::word_type [3:0] s0_a_ff;
   qau_pkg::word_type [3:0] s0_b_ff;
   qau_pkg::word_type       s0_s_ff;

   ctl_type                        issue_ctl;
   ctl_type                        ctl_ff [1:D];
   qau_pkg::lane_op_type           lane_op [qau_pkg::LANES];
   sgn_type [3:0]                  sgn_in;
   sgn_type [3:0]                  sgn_ff [1:qau_pkg::SQRT_LAT];
   qau_pkg::lane_res_type [3:0]    mac_res;
   qau_pkg::lane_res_type [3:0]    md_ff [qau_pkg::MAC_LAT+1:D];
   logic [32:0]                    root;
   logic                           zero;
   qau_pkg::word_type [3:0]        div_res;
   logic [3:0]                     div_clr;

   qau_pkg::word_type [3:0] elem_in;
   logic                    sat_in;
   logic                    zero_in;
   logic                    rsp_valid_ff;
   qau_pkg::word_type [3:0] elem_ff;
   logic [1:0]              row_ff;
   logic                    last_ff;
   logic                    sat_ff;
   logic                    zero_ff;

   assign adv = !rsp_valid_ff || !rsp_stall;
   assign more = s0_valid_ff && (s0_kind_ff == qau_pkg::KIND_MAT) && (s0_row_ff != LAST_ROW);
   assign req_stall = !adv || more;

   // issue stage: a matrix item stays for one row per cycle while the pipeline advances
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s0_row_ff <= '0;
      end else if (adv) begin
         if (more) begin
            s0_row_ff <= s0_row_ff + 2'd1;
         end else begin
            s0_valid_ff <= req_valid;
            s0_row_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv && !more && req_valid) begin
         s0_kind_ff <= req_kind;
         s0_a_ff <= {req_a_k, req_a_j, req_a_i, req_a_r};
         s0_b_ff <= {req_b_k, req_b_j, req_b_i, req_b_r};
         s0_s_ff <= req_scale;
      end
   end

   always_comb begin
      issue_ctl.valid = s0_valid_ff && (s0_kind_ff <= qau_pkg::KIND_MAT);
      issue_ctl.norm = (s0_kind_ff == qau_pkg::KIND_NORM);
      issue_ctl.row = (s0_kind_ff == qau_pkg::KIND_MAT) ? s0_row_ff : 2'd0;
      issue_ctl.last = (s0_kind_ff != qau_pkg::KIND_MAT) || (s0_row_ff == LAST_ROW);
      for (int g = 0; g < qau_pkg::LANES; g++) begin
         lane_op[g] = sel_op(s0_kind_ff, s0_row_ff, 2'(g), s0_a_ff, s0_b_ff, s0_s_ff);
         sgn_in[g].neg = s0_a_ff[g][31];
         sgn_in[g].mag = s0_a_ff[g][31] ? (32'(~s0_a_ff[g]) + 32'd1) : 32'(s0_a_ff[g]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i <= D; i++) ctl_ff[i] <= '0;
      end else if (adv) begin
         ctl_ff[1] <= issue_ctl;
         for (int i = 2; i <= D; i++) ctl_ff[i] <= ctl_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sgn_ff[1] <= sgn_in;
         for (int i = 2; i <= qau_pkg::SQRT_LAT; i++) sgn_ff[i] <= sgn_ff[i-1];
         md_ff[qau_pkg::MAC_LAT+1] <= mac_res;
         for (int i = qau_pkg::MAC_LAT + 2; i <= D; i++) md_ff[i] <= md_ff[i-1];
      end
   end

   qau_sqrt u_sqrt (
      .clock (clock),
      .en    (adv),
      .a     (s0_a_ff),
      .root  (root),
      .zero  (zero)
   );

   for (genvar g = 0; g < qau_pkg::LANES; g++) begin : g_lane
      qau_mac u_mac (
         .clock (clock),
         .en    (adv),
         .op    (lane_op[g]),
         .res   (mac_res[g])
      );
      qau_div u_div (
         .clock (clock),
         .en    (adv),
         .mag   (sgn_ff[qau_pkg::SQRT_LAT][g].mag),
         .root  (root),
         .neg   (sgn_ff[qau_pkg::SQRT_LAT][g].neg),
         .clr   (zero),
         .quot  (div_res[g]),
         .clr_o (div_clr[g])
      );
   end

   // merge: pick normalize or product path, fold the lane clip flags
   always_comb begin
      sat_in = 1'b0;
      for (int g = 0; g < qau_pkg::LANES; g++) begin
         elem_in[g] = ctl_ff[D].norm ? div_res[g] : md_ff[D][g].elem;
         sat_in = sat_in | (!ctl_ff[D].norm && md_ff[D][g].sat);
      end
      zero_in = ctl_ff[D].norm && (&div_clr);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= ctl_ff[D].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         elem_ff <= elem_in;
         row_ff <= ctl_ff[D].row;
         last_ff <= ctl_ff[D].last;
         sat_ff <= sat_in;
         zero_ff <= zero_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_elem_0 = elem_ff[0];
   assign rsp_elem_1 = elem_ff[1];
   assign rsp_elem_2 = elem_ff[2];
   assign rsp_elem_3 = elem_ff[3];
   assign rsp_row = row_ff;
   assign rsp_last = last_ff;
   assign rsp_saturated = sat_ff;
   assign rsp_zero_magnitude = zero_ff;

endmodule
